@@ rtl/core/rat_pkg.sv @@
// Shared types, sizes and codes of the reminder alarm table.
// Used by the entry matcher and the top level; depends on nothing.
package rat_pkg;

    // Table size and the index and count widths that follow from it.
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Operation codes carried in the input tuser.
    localparam logic [2:0] F_CHECK     = 3'd0;
    localparam logic [2:0] F_ADD       = 3'd1;
    localparam logic [2:0] F_REMOVE    = 3'd2;
    localparam logic [2:0] F_CLR_SHOWN = 3'd3;
    localparam logic [2:0] F_CLR_ALL   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    // Lead window register limits and reset value.
    localparam logic [5:0] LEAD_RESET = 6'd5;
    localparam logic [5:0] LEAD_FLOOR = 6'd1;
    localparam logic [5:0] LEAD_MAX   = 6'd60;

    // Clock arithmetic constants.
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;
    localparam logic [4:0]  HALF_DAY     = 5'd12;
    localparam logic [4:0]  FULL_DAY     = 5'd24;

    // One stored alarm entry.
    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        kind;
        logic [6:0]  mask;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_entry;

    // Current time and date presented by a check.
    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  wday;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_now;

    // Verdict of the matcher on one entry.
    typedef struct packed {
        logic       hit;
        logic [3:0] disp_hour;
        logic       is_pm;
    } t_match;

endpackage

@@ rtl/core/reminder_alarm_table.sv @@
// Reminder alarm table: top level with the operation sequencer; uses rat_pkg, rat_ram, rat_match.
// Each item passes IDLE, EXEC and DONE; a check of a non-empty table adds a SCAN of the stored
// entries, and a remove that moves entries adds a MOVE that shifts them down one place.
// One item is in work at a time, one entry a cycle through the RAM read port; a new item is taken
// only once the last result is loaded, and a finished result waits in the output register meanwhile.
// Reset (synchronous, active low) empties the table and sets the lead window to 5 minutes.
module reminder_alarm_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: lead window length in minutes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: hour[4:0], minute[10:5], weekday[13:11], year[29:14], month[33:30],
    //        day[38:34], day_mask[45:39], slot[51:46], zero[55:52]
    input  logic [55:0] i_s_tdata,
    // tuser: func[2:0], entry_kind[3]
    input  logic [3:0]  i_s_tuser,
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: match_index[5:0], meet_hour[10:6], meet_minute[16:11],
    //        display_hour[20:17], is_pm[21], entry_count[28:22], zero[31:29]
    output logic [31:0] o_m_tdata,
    // tuser: found[0], status[2:1]
    output logic [2:0]  o_m_tuser
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int D = rat_pkg::TABLE_DEPTH;

    // Control state.
    logic [2:0]                 r_state, n_state;
    rat_pkg::t_cnt              r_fill, n_fill;
    logic [D-1:0]               r_shown, n_shown;
    logic [5:0]                 r_lead, n_lead;
    rat_pkg::t_cnt              r_rd_ptr, n_rd_ptr;
    logic                       r_ev_valid, n_ev_valid;
    rat_pkg::t_cnt              r_ev_idx, n_ev_idx;
    logic                       r_o_valid, n_o_valid;

    // Latched input item.
    logic [2:0]                 r_func, n_func;
    rat_pkg::t_entry            r_ent, n_ent;
    rat_pkg::t_now              r_now, n_now;
    logic [5:0]                 r_slot, n_slot;

    // Result staging and output payload.
    logic                       r_res_found, n_res_found;
    logic [1:0]                 r_res_status, n_res_status;
    logic [5:0]                 r_res_idx, n_res_idx;
    logic [4:0]                 r_res_mh, n_res_mh;
    logic [5:0]                 r_res_mm, n_res_mm;
    logic [3:0]                 r_res_dh, n_res_dh;
    logic                       r_res_pm, n_res_pm;
    logic [31:0]                r_o_tdata, n_o_tdata;
    logic [2:0]                 r_o_tuser, n_o_tuser;

    // Entry RAM ports.
    logic                       ram_we;
    rat_pkg::t_addr             ram_waddr;
    rat_pkg::t_entry            ram_wdata;
    rat_pkg::t_addr             ram_raddr;
    rat_pkg::t_entry            ram_rdata;

    logic                       in_xfer;
    logic [5:0]                 cfg_clamped;
    logic [6:0]                 fill_ext;
    logic [6:0]                 slot_p1;
    rat_pkg::t_cnt              ev_prev;
    rat_pkg::t_cnt              fill_last;
    logic [D:0]                 shown_up;
    rat_pkg::t_match            match;

    rat_ram #(
        .WIDTH ($bits(rat_pkg::t_entry)),
        .DEPTH (D)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rat_match u_match (
        .i_entry (ram_rdata),
        .i_shown (r_shown[r_ev_idx[rat_pkg::ADDR_W-1:0]]),
        .i_now   (r_now),
        .i_lead  (r_lead),
        .o_match (match)
    );

    // Handshake and helper values.
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign fill_ext    = 7'(r_fill);
    assign slot_p1     = 7'(r_slot) + 7'd1;
    assign ev_prev     = r_ev_idx - rat_pkg::t_cnt'(1);
    assign fill_last   = r_fill - rat_pkg::t_cnt'(1);
    assign shown_up    = {1'b0, r_shown};

    // Lead window write, clamped to its legal range.
    always_comb begin
        if (i_cfg_data < rat_pkg::LEAD_FLOOR) begin
            cfg_clamped = rat_pkg::LEAD_FLOOR;
        end else if (i_cfg_data > rat_pkg::LEAD_MAX) begin
            cfg_clamped = rat_pkg::LEAD_MAX;
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    // Sequencer: dispatch, RAM scan for check, RAM shift for remove, result load.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_shown      = r_shown;
        n_lead       = i_cfg_valid ? cfg_clamped : r_lead;
        n_rd_ptr     = r_rd_ptr;
        n_ev_valid   = r_ev_valid;
        n_ev_idx     = r_ev_idx;
        n_o_valid    = r_o_valid && !i_m_tready;
        n_func       = r_func;
        n_ent        = r_ent;
        n_now        = r_now;
        n_slot       = r_slot;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_mh     = r_res_mh;
        n_res_mm     = r_res_mm;
        n_res_dh     = r_res_dh;
        n_res_pm     = r_res_pm;
        n_o_tdata    = r_o_tdata;
        n_o_tuser    = r_o_tuser;
        ram_we       = 1'b0;
        ram_waddr    = r_fill[rat_pkg::ADDR_W-1:0];
        ram_wdata    = r_ent;
        ram_raddr    = r_rd_ptr[rat_pkg::ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_func       = i_s_tuser[2:0];
                    n_ent.hour   = i_s_tdata[4:0];
                    n_ent.minute = i_s_tdata[10:5];
                    n_ent.kind   = i_s_tuser[3];
                    n_ent.mask   = i_s_tdata[45:39];
                    n_ent.year   = i_s_tdata[29:14];
                    n_ent.month  = i_s_tdata[33:30];
                    n_ent.day    = i_s_tdata[38:34];
                    n_now.hour   = i_s_tdata[4:0];
                    n_now.minute = i_s_tdata[10:5];
                    n_now.wday   = i_s_tdata[13:11];
                    n_now.year   = i_s_tdata[29:14];
                    n_now.month  = i_s_tdata[33:30];
                    n_now.day    = i_s_tdata[38:34];
                    n_slot       = i_s_tdata[51:46];
                    n_state      = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_found  = 1'b0;
                n_res_status = rat_pkg::ST_OK;
                n_res_idx    = 6'd0;
                n_res_mh     = 5'd0;
                n_res_mm     = 6'd0;
                n_res_dh     = 4'd0;
                n_res_pm     = 1'b0;
                n_rd_ptr     = '0;
                n_ev_valid   = 1'b0;
                n_state      = S_DONE;
                case (r_func)
                    rat_pkg::F_CHECK: begin
                        if (r_fill != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    rat_pkg::F_ADD: begin
                        if (fill_ext >= 7'(D)) begin
                            n_res_status = rat_pkg::ST_FULL;
                        end else begin
                            ram_we = 1'b1;
                            n_shown[r_fill[rat_pkg::ADDR_W-1:0]] = 1'b0;
                            n_fill = r_fill + rat_pkg::t_cnt'(1);
                        end
                    end
                    rat_pkg::F_REMOVE: begin
                        if (7'(r_slot) >= fill_ext) begin
                            n_res_status = rat_pkg::ST_BAD_INDEX;
                        end else begin
                            // Shown flags shift down in one step; entries follow over cycles.
                            for (int i = 0; i < D; i++) begin
                                if (7'(i) >= 7'(r_slot)) begin
                                    n_shown[i] = shown_up[i+1];
                                end
                            end
                            if (slot_p1 >= fill_ext) begin
                                n_fill = fill_last;
                            end else begin
                                n_rd_ptr = rat_pkg::t_cnt'(slot_p1);
                                n_state  = S_MOVE;
                            end
                        end
                    end
                    rat_pkg::F_CLR_SHOWN: begin
                        n_shown = '0;
                    end
                    rat_pkg::F_CLR_ALL: begin
                        n_shown = '0;
                        n_fill  = '0;
                    end
                    default: begin
                    end
                endcase
            end

            S_SCAN: begin
                // Issue the next read; evaluate the entry from the previous read.
                if (r_rd_ptr < r_fill) begin
                    n_rd_ptr   = r_rd_ptr + rat_pkg::t_cnt'(1);
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_rd_ptr;
                end else begin
                    n_ev_valid = 1'b0;
                end
                if (r_ev_valid) begin
                    if (match.hit) begin
                        n_res_found = 1'b1;
                        n_res_idx   = 6'(r_ev_idx);
                        n_res_mh    = ram_rdata.hour;
                        n_res_mm    = ram_rdata.minute;
                        n_res_dh    = match.disp_hour;
                        n_res_pm    = match.is_pm;
                        n_shown[r_ev_idx[rat_pkg::ADDR_W-1:0]] = 1'b1;
                        n_ev_valid  = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_ev_idx == fill_last) begin
                        n_ev_valid = 1'b0;
                        n_state    = S_DONE;
                    end
                end
            end

            S_MOVE: begin
                // Read entry k, write it back one place lower on the next cycle.
                if (r_rd_ptr < r_fill) begin
                    n_rd_ptr   = r_rd_ptr + rat_pkg::t_cnt'(1);
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_rd_ptr;
                end else begin
                    n_ev_valid = 1'b0;
                end
                if (r_ev_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = ev_prev[rat_pkg::ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                    if (r_ev_idx == fill_last) begin
                        n_fill     = fill_last;
                        n_ev_valid = 1'b0;
                        n_state    = S_DONE;
                    end
                end
            end

            S_DONE: begin
                // Load the output register once it is free or being drained.
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_tdata = {3'd0, 7'(r_fill), r_res_pm, r_res_dh, r_res_mm,
                                 r_res_mh, r_res_idx};
                    n_o_tuser = {r_res_status, r_res_found};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_shown    <= '0;
            r_lead     <= rat_pkg::LEAD_RESET;
            r_rd_ptr   <= '0;
            r_ev_valid <= 1'b0;
            r_ev_idx   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_shown    <= n_shown;
            r_lead     <= n_lead;
            r_rd_ptr   <= n_rd_ptr;
            r_ev_valid <= n_ev_valid;
            r_ev_idx   <= n_ev_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_ent        <= n_ent;
        r_now        <= n_now;
        r_slot       <= n_slot;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_mh     <= n_res_mh;
        r_res_mm     <= n_res_mm;
        r_res_dh     <= n_res_dh;
        r_res_pm     <= n_res_pm;
        r_o_tdata    <= n_o_tdata;
        r_o_tuser    <= n_o_tuser;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_tdata;
    assign o_m_tuser  = r_o_tuser;

    // The fill count never exceeds the table depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_fill) <= 7'(D))
        else $error("fill count above table depth");

    // An entry under evaluation always lies below the fill count.
    a_eval_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_valid |-> (r_ev_idx < r_fill))
        else $error("evaluated entry beyond fill count");

    // During a shift the write never lands on the entry being read.
    a_move_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_ev_valid && r_rd_ptr < r_fill) |->
        (ram_raddr != ram_waddr))
        else $error("shift write collides with read");

    // A fired reminder always reports status ok.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tuser[2:1] == rat_pkg::ST_OK))
        else $error("found result with error status");

endmodule

@@ rtl/core/rat_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; width and depth come from its parameters.
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read, one of each per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rat_match.sv @@
// Window and day test of one stored entry against the current time and date,
// plus the 12-hour display form of the entry's hour. Uses rat_pkg.
module rat_match (
    input  rat_pkg::t_entry i_entry,
    input  logic            i_shown,
    input  rat_pkg::t_now   i_now,
    input  logic [5:0]      i_lead,
    output rat_pkg::t_match o_match
);

    logic [10:0] at_min;
    logic [10:0] now_min;
    logic [11:0] win_end;
    logic        time_ok;
    logic [6:0]  today;
    logic        day_ok;
    logic [4:0]  hour_mod;

    // Minutes since midnight; the window is [at - lead, at) and never wraps.
    assign at_min  = 11'(i_entry.hour) * rat_pkg::MIN_PER_HOUR + 11'(i_entry.minute);
    assign now_min = 11'(i_now.hour) * rat_pkg::MIN_PER_HOUR + 11'(i_now.minute);
    assign win_end = 12'(now_min) + 12'(i_lead);
    assign time_ok = (now_min < at_min) && (win_end >= 12'(at_min));

    // Today's bit in the Monday-first mask; weekday seven matches nothing.
    always_comb begin
        case (i_now.wday)
            3'd0:    today = 7'b100_0000;
            3'd1:    today = 7'b000_0001;
            3'd2:    today = 7'b000_0010;
            3'd3:    today = 7'b000_0100;
            3'd4:    today = 7'b000_1000;
            3'd5:    today = 7'b001_0000;
            3'd6:    today = 7'b010_0000;
            default: today = 7'b000_0000;
        endcase
    end

    // Recurring entries test the mask, one-shot entries the full date.
    assign day_ok = i_entry.kind ?
        ((i_entry.year == i_now.year) && (i_entry.month == i_now.month) &&
         (i_entry.day == i_now.day)) :
        ((i_entry.mask & today) != 7'd0);

    // Hour modulo twelve over the full five-bit range.
    always_comb begin
        if (i_entry.hour >= rat_pkg::FULL_DAY) begin
            hour_mod = i_entry.hour - rat_pkg::FULL_DAY;
        end else if (i_entry.hour >= rat_pkg::HALF_DAY) begin
            hour_mod = i_entry.hour - rat_pkg::HALF_DAY;
        end else begin
            hour_mod = i_entry.hour;
        end
    end

    assign o_match.hit       = !i_shown && time_ok && day_ok;
    assign o_match.disp_hour = (hour_mod == 5'd0) ? 4'(rat_pkg::HALF_DAY) : hour_mod[3:0];
    assign o_match.is_pm     = (i_entry.hour >= rat_pkg::HALF_DAY);

endmodule
